/* hdl/bsa_pkg.sv */
// Shared types and constants of the banker's safety allocator.
// No dependencies; every other file in hdl/ imports this package.
package bsa_pkg;

    localparam int MAX_PROCESSES_DEF = 16;
    localparam int MAX_RESOURCES_DEF = 8;
    localparam int COUNT_BITS_DEF    = 16;

    localparam int KIND_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int NP_CFG_W   = 5;
    localparam int NR_CFG_W   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PROCESSES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_RESOURCES = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_MAX   = 3'd0,
        KIND_LOAD_ALLOC = 3'd1,
        KIND_SET_AVAIL  = 3'd2,
        KIND_STAGE_REQ  = 3'd3,
        KIND_COMMIT     = 3'd4,
        KIND_CHECK      = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE         = 3'd0,
        ST_GRANTED      = 3'd1,
        ST_EXCEEDS_NEED = 3'd2,
        ST_EXCEEDS_AVL  = 3'd3,
        ST_UNSAFE       = 3'd4,
        ST_SAFE         = 3'd5,
        ST_BAD_INDEX    = 3'd6
    } status_t;

endpackage

/* hdl/bsa_cmd_if.sv */
// Command and response channel interfaces of the allocator.
// Depends on bsa_pkg for field widths.
interface bsa_cmd_if
    import bsa_pkg::*;
#(
    parameter int PW = 4,
    parameter int RW = 3,
    parameter int CW = 16
);
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [PW-1:0]     process;
    logic [RW-1:0]     resource;
    logic [CW-1:0]     amount;

    modport source (output valid, kind, process, resource, amount, input ready);
    modport sink   (input valid, kind, process, resource, amount, output ready);
endinterface

interface bsa_rsp_if
    import bsa_pkg::*;
#(
    parameter int FW = 5
);
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FW-1:0]       finished_count;

    modport source (output valid, status, finished_count, input ready);
    modport sink   (input valid, status, finished_count, output ready);
endinterface

/* hdl/bsa_tables.sv */
// Max-claim and allocation memories: one shared write address, one shared
// registered read port. Depends on bsa_pkg for the default count width.
module bsa_tables
    import bsa_pkg::*;
#(
    parameter int ADDR_W = 7,
    parameter int CW     = COUNT_BITS_DEF
)
(
    input  logic              clk,
    input  logic              max_we,
    input  logic              alloc_we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [CW-1:0]     wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [CW-1:0]     rd_max,
    output logic [CW-1:0]     rd_alloc
);
    localparam int DEPTH = 1 << ADDR_W;

    logic [CW-1:0] max_mem   [DEPTH];
    logic [CW-1:0] alloc_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (max_we)
        begin
            max_mem[waddr] <= wdata;
        end
        if (alloc_we)
        begin
            alloc_mem[waddr] <= wdata;
        end
        rd_max   <= max_mem[raddr];
        rd_alloc <= alloc_mem[raddr];
    end
endmodule

/* hdl/bankers_safety_allocator_unit.sv */
// Top level of the banker's safety allocator: command decode, request check,
// safety sweep sequencer and response register. Depends on bsa_pkg,
// bsa_cmd_if/bsa_rsp_if and bsa_tables.
//
//  channel | dir | fields                                  | handshake
//  cmd     | in  | kind, process, resource, amount         | valid/ready
//  rsp     | out | status, finished_count                  | valid/ready
//  cfg     | in  | cfg_index, cfg_wdata                    | cfg_we only
//
// After reset a clearing pass zeroes the allocation memory, one entry a cycle,
// over all 2^(PW + RW) entries (128 by default); cmd.ready stays low meanwhile.
// Max-claim loads, sets, stages, unknown kinds and bad indices go straight to
// the response state; an allocation load reads the old entry, then writes the
// new one and moves available by the change. A commit scans its row at one
// entry a cycle through the shared memory read port, then applies it one entry
// a cycle. A safety check scans each unfinished row, passes over each finished
// one, and sweeps all np rows again while the last sweep finished a row. One
// word is worked on at a time; a finished response waits in the rsp register
// while the next command is accepted.
module bankers_safety_allocator_unit
    import bsa_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = MAX_RESOURCES_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    bsa_cmd_if.sink               cmd,
    bsa_rsp_if.source             rsp
);
    localparam int CW     = COUNT_BITS;
    localparam int PW     = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RW     = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int NPW    = $clog2(MAX_PROCESSES + 1);
    localparam int RCW    = $clog2(MAX_RESOURCES + 1);
    localparam int ADDR_W = PW + RW;

    localparam logic signed [CW+1:0] AV_LO = {2'b11, {CW{1'b0}}};
    localparam logic signed [CW+1:0] AV_HI = {2'b00, {CW{1'b1}}};

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_K1_RD, S_K1_WR, S_SCAN, S_APPLY,
        S_SINIT, S_ROW, S_UPD, S_BACK, S_OUT
    } state_t;

    // saturate a widened count into the available/work range
    function automatic logic signed [CW:0] sat_av(input logic signed [CW+1:0] v);
        logic signed [CW:0] r;
        begin
            if (v < AV_LO)
            begin
                r = AV_LO[CW:0];
            end
            else if (v > AV_HI)
            begin
                r = AV_HI[CW:0];
            end
            else
            begin
                r = v[CW:0];
            end
            return r;
        end
    endfunction

    function automatic logic signed [CW:0] need_of(input logic [CW-1:0] m,
                                                   input logic [CW-1:0] a);
        return $signed({1'b0, m}) - $signed({1'b0, a});
    endfunction

    state_t               state_reg;
    logic [NP_CFG_W-1:0]  np_cfg_reg;
    logic [NR_CFG_W-1:0]  nr_cfg_reg;
    logic [NPW-1:0]       np_eff;
    logic [RCW-1:0]       nr_eff;

    // latched command word
    logic [PW-1:0]        proc_reg;
    logic [RW-1:0]        res_reg;
    logic [CW-1:0]        amt_reg;
    logic                 commit_mode_reg;

    logic signed [CW:0]   avail_reg [MAX_RESOURCES];
    logic signed [CW:0]   work_reg  [MAX_RESOURCES];
    logic [CW-1:0]        req_reg   [MAX_RESOURCES];
    logic [CW-1:0]        hold_reg  [MAX_RESOURCES];
    logic [CW-1:0]        row_reg   [MAX_RESOURCES];
    logic                 fin_reg   [MAX_PROCESSES];

    logic [ADDR_W-1:0]    clr_reg;
    logic [RCW-1:0]       iss_reg;
    logic                 pv_reg;
    logic [RW-1:0]        pr_reg;
    logic [RW-1:0]        ap_reg;
    logic [PW-1:0]        sp_reg;
    logic                 fits_reg;
    logic                 prog_reg;
    logic [NPW-1:0]       cnt_reg;
    status_t              st_reg;

    logic                 rsp_valid_reg;
    status_t              rsp_status_reg;
    logic [NPW-1:0]       rsp_count_reg;

    // memory ports
    logic                 max_we;
    logic                 alloc_we;
    logic [ADDR_W-1:0]    waddr;
    logic [CW-1:0]        wdata;
    logic [ADDR_W-1:0]    raddr;
    logic [CW-1:0]        rd_max;
    logic [CW-1:0]        rd_alloc;
    logic [PW-1:0]        rd_proc;

    logic                 accept;
    logic                 ap_last;
    logic                 pr_last;

    bsa_tables #(
        .ADDR_W (ADDR_W),
        .CW     (CW)
    ) u_tables (
        .clk      (clk),
        .max_we   (max_we),
        .alloc_we (alloc_we),
        .waddr    (waddr),
        .wdata    (wdata),
        .raddr    (raddr),
        .rd_max   (rd_max),
        .rd_alloc (rd_alloc)
    );

    // clamp the configured sizes to what the hardware holds
    always_comb
    begin
        if (np_cfg_reg == '0)
        begin
            np_eff = NPW'(1);
        end
        else if (int'(np_cfg_reg) > MAX_PROCESSES)
        begin
            np_eff = NPW'(MAX_PROCESSES);
        end
        else
        begin
            np_eff = NPW'(np_cfg_reg);
        end
        if (nr_cfg_reg == '0)
        begin
            nr_eff = RCW'(1);
        end
        else if (int'(nr_cfg_reg) > MAX_RESOURCES)
        begin
            nr_eff = RCW'(MAX_RESOURCES);
        end
        else
        begin
            nr_eff = RCW'(nr_cfg_reg);
        end
    end

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign ap_last   = (RCW'(ap_reg) == nr_eff - RCW'(1));
    assign pr_last   = (RCW'(pr_reg) == nr_eff - RCW'(1));

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_status_reg;
    assign rsp.finished_count = rsp_count_reg;

    // read address: commit and load use the command's process, the sweep its own
    assign rd_proc = (state_reg == S_ROW) ? sp_reg : proc_reg;

    always_comb
    begin
        if (state_reg == S_K1_RD)
        begin
            raddr = {proc_reg, res_reg};
        end
        else
        begin
            raddr = {rd_proc, iss_reg[RW-1:0]};
        end
    end

    // write port steering
    always_comb
    begin
        max_we   = 1'b0;
        alloc_we = 1'b0;
        waddr    = {proc_reg, res_reg};
        wdata    = amt_reg;
        unique case (state_reg)
            S_CLR:
            begin
                alloc_we = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
            end
            S_IDLE:
            begin
                max_we = accept && (cmd.kind == KIND_LOAD_MAX)
                         && (NPW'(cmd.process) < np_eff)
                         && (RCW'(cmd.resource) < nr_eff);
                waddr  = {cmd.process, cmd.resource};
                wdata  = cmd.amount;
            end
            S_K1_WR:
            begin
                alloc_we = 1'b1;
            end
            S_APPLY:
            begin
                alloc_we = 1'b1;
                waddr    = {proc_reg, ap_reg};
                wdata    = hold_reg[ap_reg] + req_reg[ap_reg];
            end
            S_BACK:
            begin
                alloc_we = 1'b1;
                waddr    = {proc_reg, ap_reg};
                wdata    = hold_reg[ap_reg];
            end
            default:
            begin
                max_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        logic              pbad;
        logic              rbad;
        logic signed [CW:0] nd;
        logic signed [CW:0] rq;
        logic              fit_now;
        logic              prog_now;
        logic [NPW-1:0]    cnt_now;
        logic              sweep_end;
        status_t           st_now;
        state_t            nxt_now;
        if (!rst_n)
        begin
            state_reg       <= S_CLR;
            np_cfg_reg      <= NP_CFG_W'(16);
            nr_cfg_reg      <= NR_CFG_W'(8);
            clr_reg         <= '0;
            iss_reg         <= '0;
            pv_reg          <= 1'b0;
            pr_reg          <= '0;
            ap_reg          <= '0;
            sp_reg          <= '0;
            fits_reg        <= 1'b0;
            prog_reg        <= 1'b0;
            cnt_reg         <= '0;
            st_reg          <= ST_DONE;
            commit_mode_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            rsp_status_reg  <= ST_DONE;
            rsp_count_reg   <= '0;
            for (int i = 0; i < MAX_RESOURCES; i++)
            begin
                avail_reg[i] <= '0;
                work_reg[i]  <= '0;
            end
            for (int i = 0; i < MAX_PROCESSES; i++)
            begin
                fin_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_NUM_PROCESSES)
                begin
                    np_cfg_reg <= NP_CFG_W'(cfg_wdata);
                end
                else
                begin
                    nr_cfg_reg <= NR_CFG_W'(cfg_wdata);
                end
            end
            // drop the response once taken, unless a new one is loaded now
            if (rsp.ready && (state_reg != S_OUT))
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + ADDR_W'(1);
                    if (&clr_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_IDLE:
                begin
                    if (accept)
                    begin
                        pbad    = NPW'(cmd.process) >= np_eff;
                        rbad    = RCW'(cmd.resource) >= nr_eff;
                        st_now  = ST_DONE;
                        nxt_now = S_OUT;
                        proc_reg <= cmd.process;
                        res_reg  <= cmd.resource;
                        amt_reg  <= cmd.amount;
                        iss_reg  <= '0;
                        pv_reg   <= 1'b0;
                        unique case (cmd.kind)
                            KIND_LOAD_MAX:
                            begin
                                if (pbad || rbad)
                                begin
                                    st_now = ST_BAD_INDEX;
                                end
                            end
                            KIND_LOAD_ALLOC:
                            begin
                                if (pbad || rbad)
                                begin
                                    st_now = ST_BAD_INDEX;
                                end
                                else
                                begin
                                    nxt_now = S_K1_RD;
                                end
                            end
                            KIND_SET_AVAIL:
                            begin
                                if (rbad)
                                begin
                                    st_now = ST_BAD_INDEX;
                                end
                                else
                                begin
                                    avail_reg[cmd.resource] <= $signed({1'b0, cmd.amount});
                                end
                            end
                            KIND_STAGE_REQ:
                            begin
                                if (rbad)
                                begin
                                    st_now = ST_BAD_INDEX;
                                end
                                else
                                begin
                                    req_reg[cmd.resource] <= cmd.amount;
                                end
                            end
                            KIND_COMMIT:
                            begin
                                if (pbad)
                                begin
                                    st_now = ST_BAD_INDEX;
                                end
                                else
                                begin
                                    nxt_now = S_SCAN;
                                end
                            end
                            KIND_CHECK:
                            begin
                                commit_mode_reg <= 1'b0;
                                nxt_now          = S_SINIT;
                            end
                            default:
                            begin
                                st_now = ST_DONE;
                            end
                        endcase
                        st_reg    <= st_now;
                        state_reg <= nxt_now;
                    end
                end

                S_K1_RD:
                begin
                    state_reg <= S_K1_WR;
                end

                S_K1_WR:
                begin
                    // move available by the change of the allocation entry
                    avail_reg[res_reg] <= sat_av(
                        (CW+2)'(avail_reg[res_reg])
                        - ((CW+2)'($signed({1'b0, amt_reg}))
                        - (CW+2)'($signed({1'b0, rd_alloc}))));
                    state_reg <= S_OUT;
                end

                S_SCAN:
                begin
                    if (iss_reg < nr_eff)
                    begin
                        iss_reg <= iss_reg + RCW'(1);
                        pv_reg  <= 1'b1;
                        pr_reg  <= iss_reg[RW-1:0];
                    end
                    else
                    begin
                        pv_reg <= 1'b0;
                    end
                    if (pv_reg)
                    begin
                        nd = need_of(rd_max, rd_alloc);
                        rq = $signed({1'b0, req_reg[pr_reg]});
                        hold_reg[pr_reg] <= rd_alloc;
                        if (rq > nd)
                        begin
                            st_reg    <= ST_EXCEEDS_NEED;
                            state_reg <= S_OUT;
                        end
                        else if (rq > avail_reg[pr_reg])
                        begin
                            st_reg    <= ST_EXCEEDS_AVL;
                            state_reg <= S_OUT;
                        end
                        else if (pr_last)
                        begin
                            ap_reg    <= '0;
                            state_reg <= S_APPLY;
                        end
                    end
                end

                S_APPLY:
                begin
                    // grant tentatively, one entry a cycle
                    avail_reg[ap_reg] <= avail_reg[ap_reg] - $signed({1'b0, req_reg[ap_reg]});
                    ap_reg <= ap_reg + RW'(1);
                    if (ap_last)
                    begin
                        commit_mode_reg <= 1'b1;
                        state_reg       <= S_SINIT;
                    end
                end

                S_SINIT:
                begin
                    for (int i = 0; i < MAX_RESOURCES; i++)
                    begin
                        work_reg[i] <= (i < int'(nr_eff)) ? avail_reg[i] : '0;
                    end
                    for (int i = 0; i < MAX_PROCESSES; i++)
                    begin
                        fin_reg[i] <= 1'b0;
                    end
                    cnt_reg   <= '0;
                    sp_reg    <= '0;
                    prog_reg  <= 1'b0;
                    iss_reg   <= '0;
                    pv_reg    <= 1'b0;
                    fits_reg  <= 1'b1;
                    state_reg <= S_ROW;
                end

                S_ROW, S_UPD:
                begin
                    fit_now   = 1'b0;
                    sweep_end = 1'b0;
                    if (state_reg == S_ROW)
                    begin
                        if (fin_reg[sp_reg])
                        begin
                            sweep_end = 1'b1;
                        end
                        else
                        begin
                            if (iss_reg < nr_eff)
                            begin
                                iss_reg <= iss_reg + RCW'(1);
                                pv_reg  <= 1'b1;
                                pr_reg  <= iss_reg[RW-1:0];
                            end
                            else
                            begin
                                pv_reg <= 1'b0;
                            end
                            if (pv_reg)
                            begin
                                nd = need_of(rd_max, rd_alloc);
                                row_reg[pr_reg] <= rd_alloc;
                                if (nd > work_reg[pr_reg])
                                begin
                                    fits_reg <= 1'b0;
                                end
                                if (pr_last)
                                begin
                                    state_reg <= S_UPD;
                                end
                            end
                        end
                    end
                    else
                    begin
                        fit_now   = fits_reg;
                        sweep_end = 1'b1;
                    end

                    // finish the row and step to the next process
                    if (sweep_end)
                    begin
                        prog_now = prog_reg || fit_now;
                        cnt_now  = cnt_reg + NPW'(fit_now);
                        if (fit_now)
                        begin
                            for (int i = 0; i < MAX_RESOURCES; i++)
                            begin
                                if (i < int'(nr_eff))
                                begin
                                    work_reg[i] <= sat_av((CW+2)'(work_reg[i])
                                        + (CW+2)'($signed({1'b0, row_reg[i]})));
                                end
                            end
                            fin_reg[sp_reg] <= 1'b1;
                        end
                        cnt_reg  <= cnt_now;
                        iss_reg  <= '0;
                        pv_reg   <= 1'b0;
                        fits_reg <= 1'b1;
                        if (NPW'(sp_reg) == np_eff - NPW'(1))
                        begin
                            sp_reg   <= '0;
                            prog_reg <= 1'b0;
                            if (prog_now)
                            begin
                                state_reg <= S_ROW;
                            end
                            else if (cnt_now == np_eff)
                            begin
                                st_reg    <= commit_mode_reg ? ST_GRANTED : ST_SAFE;
                                state_reg <= S_OUT;
                            end
                            else if (commit_mode_reg)
                            begin
                                ap_reg    <= '0;
                                state_reg <= S_BACK;
                            end
                            else
                            begin
                                st_reg    <= ST_UNSAFE;
                                state_reg <= S_OUT;
                            end
                        end
                        else
                        begin
                            sp_reg    <= sp_reg + PW'(1);
                            prog_reg  <= prog_now;
                            state_reg <= S_ROW;
                        end
                    end
                end

                S_BACK:
                begin
                    // unsafe: roll the grant back
                    avail_reg[ap_reg] <= avail_reg[ap_reg] + $signed({1'b0, req_reg[ap_reg]});
                    ap_reg <= ap_reg + RW'(1);
                    if (ap_last)
                    begin
                        st_reg    <= ST_UNSAFE;
                        state_reg <= S_OUT;
                    end
                end

                S_OUT:
                begin
                    // hold until the response register is free
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= st_reg;
                        rsp_count_reg  <= cnt_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

/* test/tb_bankers_safety_allocator_unit.sv */
// Self-checking testbench of the banker's safety allocator unit.
// Depends on bsa_pkg, the bsa_cmd_if/bsa_rsp_if interfaces and the unit RTL.
module tb_bankers_safety_allocator_unit
    import bsa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROC = MAX_PROCESSES_DEF;
    localparam int NRES  = MAX_RESOURCES_DEF;
    localparam int CMAX  = 65535;
    localparam int AVMIN = -65536;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  process;
        logic [2:0]  resource;
        logic [15:0] amount;
    } cmd_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] finished;
    } rsp_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    bsa_cmd_if cmd_ch ();
    bsa_rsp_if rsp_ch ();

    bankers_safety_allocator_unit DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .cmd(cmd_ch.sink), .rsp(rsp_ch.source)
    );

    always #10 clk = ~clk;

    // Shadow copy of the allocator state, updated as each word is accepted.
    int claim_tbl [NPROC][NRES];
    int alloc_tbl [NPROC][NRES];
    int avail_vec [NRES];
    int req_vec   [NRES];
    int work_vec  [NRES];
    bit done_mark [NPROC];
    int np_cfg, nr_cfg;

    // Track which claim/request entries hold data, so unwritten ones can be reported.
    bit claim_set [NPROC][NRES];
    bit req_set   [NRES];

    cmd_word_t pending_cmds[$];
    rsp_word_t expected_rsps[$];
    int  mismatches = 0;
    int  rsp_seen = 0;
    int  n_granted = 0, n_unsafe = 0, n_refused = 0;
    bit  timed_out = 0;
    bit  cmd_taken = 0;
    longint cycles = 0;

    function automatic int sat_count(int v);
        if (v < AVMIN) return AVMIN;
        if (v > CMAX) return CMAX;
        return v;
    endfunction

    function automatic int np_eff();
        return (np_cfg < 1) ? 1 : (np_cfg > NPROC ? NPROC : np_cfg);
    endfunction

    function automatic int nr_eff();
        return (nr_cfg < 1) ? 1 : (nr_cfg > NRES ? NRES : nr_cfg);
    endfunction

    function automatic int marks_total();
        int c;
        c = 0;
        foreach (done_mark[p]) c += done_mark[p];
        return c;
    endfunction

    // Sweep processes against the work vector until no further one finishes.
    function automatic bit run_safety();
        int np, nr, finished;
        bit progress, fits;
        np = np_eff();
        nr = nr_eff();
        finished = 0;
        foreach (done_mark[p]) done_mark[p] = 0;
        foreach (work_vec[r]) work_vec[r] = (r < nr) ? avail_vec[r] : 0;
        progress = 1;
        while (progress)
        begin
            progress = 0;
            for (int p = 0; p < np; p++)
            begin
                if (done_mark[p]) continue;
                fits = 1;
                for (int r = 0; r < nr; r++)
                    if (claim_tbl[p][r] - alloc_tbl[p][r] > work_vec[r]) fits = 0;
                if (fits)
                begin
                    for (int r = 0; r < nr; r++)
                        work_vec[r] = sat_count(work_vec[r] + alloc_tbl[p][r]);
                    done_mark[p] = 1;
                    finished++;
                    progress = 1;
                end
            end
        end
        return finished == np;
    endfunction

    function automatic rsp_word_t allocator_outcome(cmd_word_t w);
        rsp_word_t o;
        int np, nr, amt;
        bit pbad, rbad;
        status_t st;
        np = np_eff();
        nr = nr_eff();
        amt = w.amount;
        pbad = w.process >= np;
        rbad = w.resource >= nr;
        st = ST_DONE;
        case (w.kind)
            KIND_LOAD_MAX:
                if (pbad || rbad) st = ST_BAD_INDEX;
                else claim_tbl[w.process][w.resource] = amt;
            KIND_LOAD_ALLOC:
                if (pbad || rbad) st = ST_BAD_INDEX;
                else
                begin
                    avail_vec[w.resource] = sat_count(avail_vec[w.resource]
                        - (amt - alloc_tbl[w.process][w.resource]));
                    alloc_tbl[w.process][w.resource] = amt;
                end
            KIND_SET_AVAIL:
                if (rbad) st = ST_BAD_INDEX;
                else avail_vec[w.resource] = amt;
            KIND_STAGE_REQ:
                if (rbad) st = ST_BAD_INDEX;
                else req_vec[w.resource] = amt;
            KIND_COMMIT:
                if (pbad) st = ST_BAD_INDEX;
                else
                begin
                    for (int r = 0; r < nr && st == ST_DONE; r++)
                    begin
                        if (req_vec[r] > claim_tbl[w.process][r] - alloc_tbl[w.process][r])
                            st = ST_EXCEEDS_NEED;
                        else if (req_vec[r] > avail_vec[r])
                            st = ST_EXCEEDS_AVL;
                    end
                    if (st == ST_DONE)
                    begin
                        for (int r = 0; r < nr; r++)
                        begin
                            avail_vec[r] -= req_vec[r];
                            alloc_tbl[w.process][r] += req_vec[r];
                        end
                        if (run_safety()) st = ST_GRANTED;
                        else
                        begin
                            // roll the tentative grant back
                            for (int r = 0; r < nr; r++)
                            begin
                                avail_vec[r] += req_vec[r];
                                alloc_tbl[w.process][r] -= req_vec[r];
                            end
                            st = ST_UNSAFE;
                        end
                    end
                end
            KIND_CHECK:
                st = run_safety() ? ST_SAFE : ST_UNSAFE;
            default:
                st = ST_DONE;
        endcase
        o.status = st;
        o.finished = marks_total();
        return o;
    endfunction

    // Mostly no gap, often a short one, and now and then a long one.
    function automatic int gap_len();
        int d;
        d = $urandom_range(0, 99);
        if (d < 55) return 0;
        if (d < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: present queued words, change inputs on the falling edge.
    int drv_hold = 0;
    bit burst_mode = 0;
    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_ch.valid <= 1'b0;
        else if (cmd_ch.valid && !cmd_taken)
            ; // hold the word until taken
        else if (drv_hold > 0)
        begin
            cmd_ch.valid <= 1'b0;
            drv_hold <= drv_hold - 1;
        end
        else if (pending_cmds.size() > 0)
        begin
            cmd_word_t w;
            w = pending_cmds.pop_front();
            cmd_ch.valid    <= 1'b1;
            cmd_ch.kind     <= w.kind;
            cmd_ch.process  <= w.process;
            cmd_ch.resource <= w.resource;
            cmd_ch.amount   <= w.amount;
            drv_hold <= burst_mode ? 0 : gap_len();
        end
        else
            cmd_ch.valid <= 1'b0;
    end

    // Response side backpressure.
    int rdy_hold = 0;
    always @(negedge clk)
    begin
        if (rdy_hold > 0)
        begin
            rsp_ch.ready <= 1'b0;
            rdy_hold <= rdy_hold - 1;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            rdy_hold <= burst_mode ? 0 : gap_len();
        end
    end

    // Monitor: predict on command acceptance, compare on response acceptance.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles <= cycles + 1;
            cmd_taken <= cmd_ch.valid && cmd_ch.ready;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                cmd_word_t w;
                rsp_word_t e;
                w.kind = cmd_ch.kind;
                w.process = cmd_ch.process;
                w.resource = cmd_ch.resource;
                w.amount = cmd_ch.amount;
                e = allocator_outcome(w);
                if (e.status == ST_GRANTED) n_granted++;
                if (e.status == ST_UNSAFE) n_unsafe++;
                if (e.status == ST_EXCEEDS_NEED || e.status == ST_EXCEEDS_AVL) n_refused++;
                expected_rsps.push_back(e);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_seen++;
                if (expected_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response: status %0d finished %0d",
                                 rsp_ch.status, rsp_ch.finished_count);
                end
                else
                begin
                    rsp_word_t e;
                    e = expected_rsps.pop_front();
                    if (rsp_ch.status !== e.status || rsp_ch.finished_count !== e.finished)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("response %0d: expected status %0d finished %0d, got %0d %0d",
                                     rsp_seen, e.status, e.finished,
                                     rsp_ch.status, rsp_ch.finished_count);
                    end
                end
            end
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic cmd_word_t mk(kind_t k, int p, int r, int a);
        cmd_word_t w;
        w.kind = k;
        w.process = 4'(p);
        w.resource = 3'(r);
        w.amount = 16'(a);
        return w;
    endfunction

    // Queue a word, marking claim/request entries that it fills.
    task automatic push_cmd(cmd_word_t w);
        if (w.kind == KIND_LOAD_MAX && w.process < np_cfg && w.resource < nr_cfg)
            claim_set[w.process][w.resource] = 1;
        if (w.kind == KIND_STAGE_REQ && w.resource < nr_cfg)
            req_set[w.resource] = 1;
        pending_cmds.push_back(w);
    endtask

    // Fill every claim and request cell in use, so commits and checks are legal.
    task automatic load_scenario(int scale);
        for (int p = 0; p < np_cfg; p++)
            for (int r = 0; r < nr_cfg; r++)
            begin
                push_cmd(mk(KIND_LOAD_MAX, p, r, $urandom_range(0, scale)));
                if ($urandom_range(0, 1))
                    push_cmd(mk(KIND_LOAD_ALLOC, p, r, $urandom_range(0, scale / 2)));
            end
        for (int r = 0; r < nr_cfg; r++)
        begin
            push_cmd(mk(KIND_SET_AVAIL, r, r, $urandom_range(0, scale)));
            push_cmd(mk(KIND_STAGE_REQ, 0, r, $urandom_range(0, scale / 3)));
        end
    endtask

    function automatic bit all_ready();
        for (int p = 0; p < np_cfg; p++)
            for (int r = 0; r < nr_cfg; r++)
                if (!claim_set[p][r]) return 0;
        for (int r = 0; r < nr_cfg; r++)
            if (!req_set[r]) return 0;
        return 1;
    endfunction

    // Random word: mostly commits, checks and stages; some loads and noise.
    task automatic push_random(int scale);
        int d;
        kind_t k;
        d = $urandom_range(0, 99);
        if (d < 30) k = KIND_COMMIT;
        else if (d < 42) k = KIND_CHECK;
        else if (d < 62) k = KIND_STAGE_REQ;
        else if (d < 72) k = KIND_LOAD_ALLOC;
        else if (d < 80) k = KIND_LOAD_MAX;
        else if (d < 88) k = KIND_SET_AVAIL;
        else k = kind_t'($urandom_range(0, 7));
        if (d >= 95)
            push_cmd(mk(kind_t'($urandom_range(6, 7)), $urandom, $urandom, $urandom));
        else if (d >= 92)
            push_cmd(mk(k, $urandom, $urandom, $urandom)); // full-range noise
        else
            push_cmd(mk(k, $urandom_range(0, np_cfg - 1), $urandom_range(0, nr_cfg - 1),
                        $urandom_range(0, scale)));
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || cmd_ch.valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (np_eff() * np_eff() * (nr_eff() + 2) + 20) @(posedge clk);
    endtask

    // Write a register on a falling edge, one cycle wide.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_NUM_PROCESSES) np_cfg = val;
        else nr_cfg = val;
    endtask

    initial
    begin
        int settings_np[5];
        int settings_nr[5];
        settings_np = '{16, 1, 5, 3, 0};
        settings_nr = '{2, 1, 3, 8, 15};
        cmd_ch.valid = 0; cmd_ch.kind = '0; cmd_ch.process = '0;
        cmd_ch.resource = '0; cmd_ch.amount = '0;
        rsp_ch.ready = 0;
        np_cfg = 16; nr_cfg = 8;
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed opening: unknown kinds, extremes, saturation of available.
        push_cmd(mk(KIND_SET_AVAIL, 0, 0, 16'hFFFF));
        push_cmd(mk(KIND_LOAD_ALLOC, 15, 7, 16'hFFFF));
        push_cmd(mk(KIND_LOAD_ALLOC, 14, 7, 16'hFFFF)); // drive available to saturation
        push_cmd(mk(KIND_LOAD_ALLOC, 13, 7, 16'hFFFF));
        push_cmd(mk(KIND_LOAD_ALLOC, 13, 7, 0));
        push_cmd(mk(kind_t'(3'd6), 15, 7, 16'hFFFF));
        push_cmd(mk(kind_t'(3'd7), 0, 0, 0));
        push_cmd(mk(KIND_LOAD_MAX, 0, 0, 16'hFFFF));
        push_cmd(mk(KIND_STAGE_REQ, 0, 0, 0));
        wait_idle();

        // Small configs make unsafe states and bad indices easy to reach.
        for (int s = 0; s < 5; s++)
        begin
            int scale;
            write_reg(CFG_NUM_PROCESSES, settings_np[s]);
            write_reg(CFG_NUM_RESOURCES, settings_nr[s]);
            if (s == 4)
            begin
                np_cfg = 1; // saturated use: a zero means one process
                nr_cfg = 8; // and fifteen resources means eight
            end
            scale = (s == 0) ? CMAX : 12;
            load_scenario(scale);
            if (s == 1)
            begin
                push_cmd(mk(KIND_COMMIT, 1, 0, 0));      // process out of range
                push_cmd(mk(KIND_STAGE_REQ, 0, 1, 5));   // resource out of range
                push_cmd(mk(KIND_STAGE_REQ, 0, 0, 0));
                push_cmd(mk(KIND_COMMIT, 0, 0, 0));
            end
            burst_mode = (s == 2);
            for (int i = 0; i < 22; i++)
                push_random(scale);
            if (!all_ready())
                $display("setup left unwritten entries");
            wait_idle();
            burst_mode = 0;
        end

        $display("covered %0d responses over 5 process/resource settings", rsp_seen);
        $display("grants %0d, unsafe %0d, refusals %0d", n_granted, n_unsafe, n_refused);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

/* filelist.f */
hdl/bsa_pkg.sv
hdl/bsa_cmd_if.sv
hdl/bsa_tables.sv
hdl/bankers_safety_allocator_unit.sv
test/tb_bankers_safety_allocator_unit.sv
